// ===== rtl/cau_pkg.sv =====
// Shared types, widths and helpers for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

    localparam int FRAC_BITS = 8;
    localparam int PART_W    = 16;
    localparam int PROD_W    = 2 * PART_W;          // one 16x16 signed product
    localparam int SUM_W     = PROD_W + 1;          // sum or difference of two products
    localparam int D_W       = PROD_W;              // br^2 + bi^2, unsigned
    localparam int N_W       = D_W + FRAC_BITS;     // scaled dividend magnitude
    localparam int Q_W       = PART_W;              // quotient bits produced
    localparam int CMP_W     = N_W + Q_W;
    localparam int SAT_IN_W  = SUM_W + 1;
    localparam int HALF      = (FRAC_BITS > 0) ? (1 << (FRAC_BITS - 1)) : 0;
    localparam int STEPS     = 2;                   // quotient bits per divider stage
    localparam int DIV_STAGES = Q_W / STEPS;
    localparam int FRONT_STAGES = 4;
    localparam int NUM_STAGES = FRONT_STAGES + DIV_STAGES + 1;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CONJ = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    typedef struct packed {
        logic                     sat;
        logic signed [PART_W-1:0] val;
    } sat_t;

    // Sideband that travels beside the divider
    typedef struct packed {
        logic [2:0]               op;
        logic signed [PART_W-1:0] res_real;
        logic signed [PART_W-1:0] res_imag;
        logic                     sat;
        logic                     zero;
        logic                     neg_r;
        logic                     neg_i;
        logic                     ovf_r;
        logic                     ovf_i;
    } side_t;

    typedef struct packed {
        logic [D_W-1:0] rem;
        logic [Q_W-1:0] low;
        logic [Q_W-1:0] quo;
        logic [D_W-1:0] div;
    } div_t;

    function automatic sat_t sat16(input logic signed [SAT_IN_W-1:0] v);
        sat_t r;
        begin
            if (v > SAT_IN_W'(32767)) begin
                r.sat = 1'b1;
                r.val = 16'sh7fff;
            end else if (v < -SAT_IN_W'(32768)) begin
                r.sat = 1'b1;
                r.val = 16'sh8000;
            end else begin
                r.sat = 1'b0;
                r.val = v[PART_W-1:0];
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/cau_front.sv =====
// Input register, products, sums and divider setup: four pipeline stages.
`default_nettype none
module cau_front (
    input  wire logic                          aclk,
    input  wire logic [cau_pkg::FRONT_STAGES-1:0] adv,
    input  wire logic [2:0]                    op_in,
    input  wire logic signed [15:0]            ar_in,
    input  wire logic signed [15:0]            ai_in,
    input  wire logic signed [15:0]            br_in,
    input  wire logic signed [15:0]            bi_in,
    output cau_pkg::side_t                     side,
    output cau_pkg::div_t                      div_r,
    output cau_pkg::div_t                      div_i
);

    typedef struct packed {
        logic [2:0]        op;
        logic signed [15:0] ar, ai, br, bi;
    } s0_t;

    typedef struct packed {
        logic [2:0]        op;
        logic signed [15:0] ar, ai, br, bi;
        logic signed [cau_pkg::PROD_W-1:0] arbr, aibi, arbi, aibr, brbr, bibi;
    } s1_t;

    typedef struct packed {
        cau_pkg::side_t                     side;
        logic signed [cau_pkg::SUM_W-1:0]   nr, ni;
        logic [cau_pkg::D_W-1:0]            d;
    } s2_t;

    typedef struct packed {
        logic          neg;
        logic          ovf;
        cau_pkg::div_t dv;
    } prep_t;

    s0_t s0_reg, s0_next;
    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    cau_pkg::side_t side_reg, side_next;
    cau_pkg::div_t  dr_reg, dr_next, di_reg, di_next;

    function automatic prep_t prep(input logic signed [cau_pkg::SUM_W-1:0] n,
                                   input logic [cau_pkg::D_W-1:0] d);
        prep_t p;
        logic [cau_pkg::SUM_W-1:0] mag;
        logic [cau_pkg::N_W-1:0]   nn;
        begin
            p.neg = n[cau_pkg::SUM_W-1];
            mag = p.neg ? -n : n;
            nn = (cau_pkg::N_W'(mag[cau_pkg::D_W-1:0]) << cau_pkg::FRAC_BITS)
                 + cau_pkg::N_W'(d >> 1);
            p.ovf = cau_pkg::CMP_W'(nn) >= (cau_pkg::CMP_W'(d) << cau_pkg::Q_W);
            p.dv.rem = cau_pkg::D_W'(nn >> cau_pkg::Q_W);
            p.dv.low = nn[cau_pkg::Q_W-1:0];
            p.dv.quo = '0;
            p.dv.div = d;
            return p;
        end
    endfunction

    always_comb begin
        s0_next.op = op_in;
        s0_next.ar = ar_in;
        s0_next.ai = ai_in;
        s0_next.br = br_in;
        s0_next.bi = bi_in;
    end

    always_comb begin
        s1_next.op = s0_reg.op;
        s1_next.ar = s0_reg.ar;
        s1_next.ai = s0_reg.ai;
        s1_next.br = s0_reg.br;
        s1_next.bi = s0_reg.bi;
        s1_next.arbr = s0_reg.ar * s0_reg.br;
        s1_next.aibi = s0_reg.ai * s0_reg.bi;
        s1_next.arbi = s0_reg.ar * s0_reg.bi;
        s1_next.aibr = s0_reg.ai * s0_reg.br;
        s1_next.brbr = s0_reg.br * s0_reg.br;
        s1_next.bibi = s0_reg.bi * s0_reg.bi;
    end

    always_comb begin
        logic signed [cau_pkg::SUM_W-1:0]    mr, mi;
        logic signed [cau_pkg::SAT_IN_W-1:0] vr, vi;
        cau_pkg::sat_t                       qr, qi;
        mr = cau_pkg::SUM_W'(s1_reg.arbr) - cau_pkg::SUM_W'(s1_reg.aibi);
        mi = cau_pkg::SUM_W'(s1_reg.arbi) + cau_pkg::SUM_W'(s1_reg.aibr);
        case (s1_reg.op)
            cau_pkg::OP_ADD: begin
                vr = cau_pkg::SAT_IN_W'(s1_reg.ar) + cau_pkg::SAT_IN_W'(s1_reg.br);
                vi = cau_pkg::SAT_IN_W'(s1_reg.ai) + cau_pkg::SAT_IN_W'(s1_reg.bi);
            end
            cau_pkg::OP_SUB: begin
                vr = cau_pkg::SAT_IN_W'(s1_reg.ar) - cau_pkg::SAT_IN_W'(s1_reg.br);
                vi = cau_pkg::SAT_IN_W'(s1_reg.ai) - cau_pkg::SAT_IN_W'(s1_reg.bi);
            end
            cau_pkg::OP_MUL: begin
                // round half up, then floor
                vr = (cau_pkg::SAT_IN_W'(mr) + cau_pkg::SAT_IN_W'(cau_pkg::HALF))
                     >>> cau_pkg::FRAC_BITS;
                vi = (cau_pkg::SAT_IN_W'(mi) + cau_pkg::SAT_IN_W'(cau_pkg::HALF))
                     >>> cau_pkg::FRAC_BITS;
            end
            cau_pkg::OP_CONJ: begin
                vr = cau_pkg::SAT_IN_W'(s1_reg.ar);
                vi = -cau_pkg::SAT_IN_W'(s1_reg.ai);
            end
            default: begin
                vr = '0;
                vi = '0;
            end
        endcase
        qr = cau_pkg::sat16(vr);
        qi = cau_pkg::sat16(vi);
        s2_next.side.op       = s1_reg.op;
        s2_next.side.res_real = qr.val;
        s2_next.side.res_imag = qi.val;
        s2_next.side.sat      = qr.sat | qi.sat;
        s2_next.d    = cau_pkg::D_W'(s1_reg.brbr) + cau_pkg::D_W'(s1_reg.bibi);
        s2_next.side.zero     = (s2_next.d == '0);
        s2_next.side.neg_r    = 1'b0;
        s2_next.side.neg_i    = 1'b0;
        s2_next.side.ovf_r    = 1'b0;
        s2_next.side.ovf_i    = 1'b0;
        s2_next.nr = cau_pkg::SUM_W'(s1_reg.arbr) + cau_pkg::SUM_W'(s1_reg.aibi);
        s2_next.ni = cau_pkg::SUM_W'(s1_reg.aibr) - cau_pkg::SUM_W'(s1_reg.arbi);
    end

    always_comb begin
        prep_t pr, pi;
        pr = prep(s2_reg.nr, s2_reg.d);
        pi = prep(s2_reg.ni, s2_reg.d);
        side_next       = s2_reg.side;
        side_next.neg_r = pr.neg;
        side_next.neg_i = pi.neg;
        side_next.ovf_r = pr.ovf;
        side_next.ovf_i = pi.ovf;
        dr_next = pr.dv;
        di_next = pi.dv;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s0_reg <= s0_next;
        end
        if (adv[1]) begin
            s1_reg <= s1_next;
        end
        if (adv[2]) begin
            s2_reg <= s2_next;
        end
        if (adv[3]) begin
            side_reg <= side_next;
            dr_reg   <= dr_next;
            di_reg   <= di_next;
        end
    end

    assign side  = side_reg;
    assign div_r = dr_reg;
    assign div_i = di_reg;

endmodule
`default_nettype wire

// ===== rtl/cau_div_pipe.sv =====
// Pipelined restoring divider: two quotient bits per stage.
`default_nettype none
module cau_div_pipe (
    input  wire logic                              aclk,
    input  wire logic [cau_pkg::DIV_STAGES-1:0]    adv,
    input  wire cau_pkg::div_t                     din,
    output logic [cau_pkg::Q_W-1:0]                quo
);

    cau_pkg::div_t stage_reg [cau_pkg::DIV_STAGES];

    function automatic cau_pkg::div_t div_step(input cau_pkg::div_t x);
        cau_pkg::div_t     y;
        logic [cau_pkg::D_W:0] t;
        begin
            y = x;
            for (int i = 0; i < cau_pkg::STEPS; i++) begin
                t = {y.rem, y.low[cau_pkg::Q_W-1]};
                y.low = y.low << 1;
                if (t >= {1'b0, y.div}) begin
                    y.rem = cau_pkg::D_W'(t - {1'b0, y.div});
                    y.quo = {y.quo[cau_pkg::Q_W-2:0], 1'b1};
                end else begin
                    y.rem = t[cau_pkg::D_W-1:0];
                    y.quo = {y.quo[cau_pkg::Q_W-2:0], 1'b0};
                end
            end
            return y;
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            stage_reg[0] <= div_step(din);
        end
    end

    for (genvar k = 1; k < cau_pkg::DIV_STAGES; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                stage_reg[k] <= div_step(stage_reg[k-1]);
            end
        end
    end

    assign quo = stage_reg[cau_pkg::DIV_STAGES-1].quo;

endmodule
`default_nettype wire

// ===== rtl/complex_arith_unit_core.sv =====
// Throughput: one word per cycle while the output does not stall; the unit is four front
// stages (input, products, sums, divider setup), eight divider stages of two quotient bits each, one output stage.
// A stalled output holds each full stage with no empty stage after it; empty stages still fill.
// Reset (aresetn low, synchronous) clears all valid bits; data registers keep contents.
`default_nettype none
module complex_arith_unit_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] req_type, [18:3] a_real, [34:19] a_imag, [50:35] b_real,
    // [66:51] b_imag, [71:67] zero
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] res_real, [31:16] res_imag, [33:32] status, [39:34] zero
    output logic [39:0]      m_tdata
);

    localparam int NS = cau_pkg::NUM_STAGES;
    localparam int FS = cau_pkg::FRONT_STAGES;
    localparam int DS = cau_pkg::DIV_STAGES;

    logic [NS-1:0] valid_reg, valid_next;
    logic [NS-1:0] adv;

    cau_pkg::side_t side3;
    cau_pkg::div_t  div_r, div_i;
    logic [cau_pkg::Q_W-1:0] quo_r, quo_i;
    cau_pkg::side_t sb_reg [DS];

    logic signed [15:0] res_real_reg, res_real_next;
    logic signed [15:0] res_imag_reg, res_imag_next;
    logic [1:0]         status_reg, status_next;

    // advance a stage when it is empty or its successor advances
    assign adv[NS-1] = !valid_reg[NS-1] || m_tready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_adv
        assign adv[k] = !valid_reg[k] || adv[k+1];
    end

    always_comb begin
        valid_next[0] = adv[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NS; k++) begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    cau_front u_front (
        .aclk  (aclk),
        .adv   (adv[FS-1:0]),
        .op_in (s_tdata[2:0]),
        .ar_in (s_tdata[18:3]),
        .ai_in (s_tdata[34:19]),
        .br_in (s_tdata[50:35]),
        .bi_in (s_tdata[66:51]),
        .side  (side3),
        .div_r (div_r),
        .div_i (div_i)
    );

    cau_div_pipe u_div_r (
        .aclk (aclk),
        .adv  (adv[FS+DS-1:FS]),
        .din  (div_r),
        .quo  (quo_r)
    );

    cau_div_pipe u_div_i (
        .aclk (aclk),
        .adv  (adv[FS+DS-1:FS]),
        .din  (div_i),
        .quo  (quo_i)
    );

    always_ff @(posedge aclk) begin
        if (adv[FS]) begin
            sb_reg[0] <= side3;
        end
    end

    for (genvar k = 1; k < DS; k++) begin : g_sb
        always_ff @(posedge aclk) begin
            if (adv[FS+k]) begin
                sb_reg[k] <= sb_reg[k-1];
            end
        end
    end

    function automatic cau_pkg::sat_t div_final(input logic [cau_pkg::Q_W-1:0] q,
                                                input logic neg, input logic ovf);
        cau_pkg::sat_t r;
        logic signed [cau_pkg::Q_W+1:0] v;
        begin
            if (ovf) begin
                r.sat = 1'b1;
                r.val = neg ? 16'sh8000 : 16'sh7fff;
            end else begin
                v = $signed({2'b00, q});
                if (neg) begin
                    v = -v;
                end
                r = cau_pkg::sat16(cau_pkg::SAT_IN_W'(v));
            end
            return r;
        end
    endfunction

    always_comb begin
        cau_pkg::side_t sb;
        cau_pkg::sat_t  fr, fi;
        sb = sb_reg[DS-1];
        fr = div_final(quo_r, sb.neg_r, sb.ovf_r);
        fi = div_final(quo_i, sb.neg_i, sb.ovf_i);
        if (sb.op == cau_pkg::OP_DIV) begin
            if (sb.zero) begin
                res_real_next = '0;
                res_imag_next = '0;
                status_next   = cau_pkg::ST_DIVZ;
            end else begin
                res_real_next = fr.val;
                res_imag_next = fi.val;
                status_next   = (fr.sat || fi.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
        end else begin
            res_real_next = sb.res_real;
            res_imag_next = sb.res_imag;
            status_next   = sb.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[NS-1]) begin
            res_real_reg <= res_real_next;
            res_imag_reg <= res_imag_next;
            status_reg   <= status_next;
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = {6'b0, status_reg, res_imag_reg, res_real_reg};

    a_divz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status_reg == cau_pkg::ST_DIVZ |-> res_real_reg == '0 && res_imag_reg == '0)
        else $error("divide-by-zero word carries nonzero parts");

    a_sat_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status_reg == cau_pkg::ST_SAT |->
            res_real_reg == 16'sh7fff || res_real_reg == 16'sh8000 ||
            res_imag_reg == 16'sh7fff || res_imag_reg == 16'sh8000)
        else $error("saturation status without a clamped part");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg) && !m_tready |-> !s_tready)
        else $error("input taken while every stage is full and output stalled");

    a_hold_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready) && !(m_tvalid && m_tready) |=>
            $countones(valid_reg) == $countones($past(valid_reg)))
        else $error("word count in pipeline changed without a handshake");

endmodule
`default_nettype wire
